### design/mtc_pkg.sv
// package for the minutia triangle code block
// widths, store depth and code constants; no dependencies
`default_nettype none
package mtc_pkg;
  localparam int MaxPoints = 64;
  localparam int IdxBits = 6;
  localparam int CntBits = 7;
  localparam int CoordBits = 10;
  localparam int AngBits = 9;
  localparam int SqBits = 2 * CoordBits + 1;
  localparam int RootBits = CoordBits + 1;
  localparam logic [SqBits-1:0] NoneSq = SqBits'(1000000);

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic sel_fetch;
    logic sqrt_start;
    logic finish;
    logic clear;
  } mtc_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic sqrt_done;
    logic sqrt_sel_done;
  } mtc_stat_t;
endpackage
`default_nettype wire

### design/mtc_isqrt.sv
// bit-serial integer square root, one result bit per cycle
// depends on mtc_pkg
`default_nettype none
module mtc_isqrt (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [mtc_pkg::SqBits-1:0] value,
  output logic done,
  output logic [mtc_pkg::RootBits-1:0] root
);
  import mtc_pkg::*;
  localparam int RemBits = SqBits + 2;
  localparam int StepBits = $clog2(RootBits + 1);
  logic [2*RootBits-1:0] rad;
  logic [RemBits-1:0] rem;
  logic [StepBits-1:0] steps;
  logic busy;
  logic [RemBits-1:0] rem_shift;
  logic [RemBits-1:0] trial;

  always_comb begin
    rem_shift = {rem[RemBits-3:0], rad[2*RootBits-1 -: 2]};
    trial = {{(RemBits-RootBits-2){1'b0}}, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rad <= (2*RootBits)'(value);
        rem <= '0;
        root <= '0;
        steps <= StepBits'(RootBits);
      end else if (busy) begin
        rad <= {rad[2*RootBits-3:0], 2'b00};
        if (rem_shift >= trial) begin
          rem <= rem_shift - trial;
          root <= {root[RootBits-2:0], 1'b1};
        end else begin
          rem <= rem_shift;
          root <= {root[RootBits-2:0], 1'b0};
        end
        steps <= steps - 1'b1;
        if (steps == StepBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### design/mtc_datapath.sv
// point stores, neighbor scan, roots and code packing
// depends on mtc_pkg and mtc_isqrt
`default_nettype none
module mtc_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire mtc_pkg::mtc_cmd_t cmd,
  input  wire logic [9:0] pos_x,
  input  wire logic [9:0] pos_y,
  input  wire logic [8:0] angle,
  output mtc_pkg::mtc_stat_t stat,
  output logic [15:0] code,
  output logic [5:0] point_index,
  output logic last_code
);
  import mtc_pkg::*;
  logic [CoordBits-1:0] xs [MaxPoints];
  logic [CoordBits-1:0] ys [MaxPoints];
  logic [AngBits-1:0] as [MaxPoints];
  logic [CntBits-1:0] count;
  logic [IdxBits-1:0] p, i, i0, i1;
  logic [IdxBits-1:0] ri;
  logic [CntBits-1:0] i_cnt;
  logic [CoordBits-1:0] px, py, rx, ry, n0x, n0y;
  logic [AngBits-1:0] pa, ra, a0r, a1r;
  logic [SqBits-1:0] b0, b1, sq;
  logic rvalid;
  logic [1:0] sel;
  logic [RootBits-1:0] f0, f1, f2, root;
  logic sq_start, sq_done;
  logic [SqBits-1:0] sq_in;
  logic [CoordBits-1:0] dx, dy;
  logic [2*CoordBits-1:0] mx, my;
  logic mvalid;
  logic [IdxBits-1:0] mi;
  logic [CoordBits-1:0] ex, ey;
  logic [2*CoordBits-1:0] ex_sq, ey_sq;

  always_comb begin
    dx = (rx > px) ? rx - px : px - rx;
    dy = (ry > py) ? ry - py : py - ry;
    ex = (rx > n0x) ? rx - n0x : n0x - rx;
    ey = (ry > n0y) ? ry - n0y : n0y - ry;
    ex_sq = ex * ex;
    ey_sq = ey * ey;
    sq = SqBits'(mx) + SqBits'(my);
  end

  always_ff @(posedge clk) begin
    if (cmd.load && count != CntBits'(MaxPoints)) begin
      xs[count[IdxBits-1:0]] <= pos_x[CoordBits-1:0];
      ys[count[IdxBits-1:0]] <= pos_y[CoordBits-1:0];
      as[count[IdxBits-1:0]] <= angle;
    end
    rx <= xs[i];
    ry <= ys[i];
    ra <= as[i];
    ri <= i;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rvalid <= 1'b0;
      mvalid <= 1'b0;
      p <= '0;
    end else begin
      if (cmd.clear) count <= '0;
      else if (cmd.load && count != CntBits'(MaxPoints)) count <= count + 1'b1;
      rvalid <= cmd.scan_step;
      mvalid <= rvalid;
      mi <= ri;
      mx <= dx * dx;
      my <= dy * dy;
      if (cmd.scan_start) begin
        i <= '0;
        i_cnt <= '0;
        b0 <= NoneSq;
        b1 <= NoneSq;
        i0 <= '0;
        i1 <= '0;
      end else if (cmd.scan_step) begin
        i <= i + 1'b1;
        i_cnt <= i_cnt + 1'b1;
      end else if (cmd.sel_fetch) begin
        i <= i0;
      end else if (cmd.sqrt_start) begin
        i <= i1;
      end
      if (cmd.scan_start) begin
        px <= xs[p];
        py <= ys[p];
        pa <= as[p];
      end
      if (mvalid && !cmd.scan_start) begin
        if (mi != p && sq != '0 && sq < b1) begin
          if (sq < b0) begin
            b0 <= sq; i0 <= mi; b1 <= b0; i1 <= i0;
          end else begin
            b1 <= sq; i1 <= mi;
          end
        end
      end
      if (cmd.finish) p <= cmd.clear ? '0 : p + 1'b1;
    end
  end

  // neighbor fetch sequencing for roots: sel 0 b0, 1 b1, 2 d2
  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= '0;
      sq_start <= 1'b0;
    end else begin
      sq_start <= 1'b0;
      if (cmd.sqrt_start) begin
        sel <= 2'd0;
        sq_in <= b0;
        sq_start <= 1'b1;
        n0x <= rx;
        n0y <= ry;
        a0r <= ra;
      end else if (sq_done) begin
        unique case (sel)
          2'd0: begin
            f0 <= root; sel <= 2'd1; sq_in <= b1; sq_start <= 1'b1;
            a1r <= ra;
          end
          2'd1: begin
            f1 <= root; sel <= 2'd2; sq_start <= 1'b1;
            sq_in <= SqBits'(ex_sq) + SqBits'(ey_sq);
          end
          default: begin
            f2 <= root; sel <= 2'd3;
          end
        endcase
      end
    end
  end

  mtc_isqrt u_sqrt (.clk(clk), .rst(rst), .start(sq_start), .value(sq_in),
    .done(sq_done), .root(root));

  logic [9:0] s0, s1, s2, t0, t1, td;
  logic [12:0] q0s, q1s;
  logic [29:0] q0m, q1m, q2m;
  logic [2:0] q0, q1, q2, g0, g1;
  logic cbit;
  function automatic logic [9:0] adiff(input logic [AngBits-1:0] a, input logic [AngBits-1:0] b);
    adiff = (a > b) ? 10'(a - b) : 10'(b - a);
  endfunction
  function automatic logic [9:0] fraw(input logic [9:0] s);
    fraw = (s > 10'd180) ? 10'd360 - s : s;
  endfunction
  // low three bits of floor(v / 45) by reciprocal multiply, exact for v up to 540
  function automatic logic [2:0] fang(input logic [9:0] s);
    logic [9:0] f;
    logic [10:0] v;
    logic [21:0] m;
    f = fraw(s);
    v = 11'd360 + {f[9], f};
    m = {11'd0, v} * 22'd1457;
    fang = m[18:16];
  endfunction

  always_comb begin
    s0 = adiff(a0r, pa);
    s1 = adiff(a1r, pa);
    s2 = adiff(a0r, a1r);
    t0 = fraw(s0);
    t1 = fraw(s1);
    td = ($signed(t0) > $signed(t1)) ? t0 - t1 : t1 - t0;
    cbit = (td != s2);
    g0 = fang(s0);
    g1 = fang(s1);
    q0s = 13'(f0) + 13'd60;
    q1s = 13'(f1) + 13'd55;
    // divide by 10 and 20 through a reciprocal multiply
    q0m = 30'(q0s) * 30'd52429;
    q1m = 30'(q1s) * 30'd52429;
    q2m = 30'(f2) * 30'd52429;
    q0 = q0m[21:19];
    q1 = q1m[21:19];
    q2 = q2m[22:20];
    stat.scan_last = (i_cnt == count - 1'b1) && cmd.scan_step;
    stat.sqrt_done = sq_done && sel == 2'd2;
    stat.sqrt_sel_done = (p == count[IdxBits-1:0] - 1'b1) ||
      (count == CntBits'(MaxPoints) && p == IdxBits'(MaxPoints-1));
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      code <= {q0, q1, q2, g0, g1, cbit};
      point_index <= p;
      last_code <= stat.sqrt_sel_done;
    end
  end
endmodule
`default_nettype wire

### design/mtc_ctrl.sv
// sequencer: load, scan, root phases and result strobe
// depends on mtc_pkg
`default_nettype none
module mtc_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic last_point,
  input  wire mtc_pkg::mtc_stat_t stat,
  output mtc_pkg::mtc_cmd_t cmd,
  output logic busy,
  output logic valid
);
  import mtc_pkg::*;
  typedef enum logic [2:0] {IDLE, SETUP, SCAN, DRAIN, FETCH, ROOT, EMIT} state_t;
  state_t state;
  logic [1:0] wait_cnt;

  always_comb begin
    cmd = '0;
    cmd.load = start && !busy;
    cmd.scan_start = state == SETUP;
    cmd.scan_step = state == SCAN;
    cmd.sel_fetch = state == DRAIN && wait_cnt == 2'd3;
    cmd.sqrt_start = state == FETCH && wait_cnt == 2'd1;
    cmd.finish = state == EMIT;
    cmd.clear = state == EMIT && stat.sqrt_sel_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy <= 1'b0;
      valid <= 1'b0;
      wait_cnt <= '0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        IDLE: if (start && last_point) begin
          state <= SETUP; busy <= 1'b1;
        end
        SETUP: state <= SCAN;
        SCAN: if (stat.scan_last) begin
          state <= DRAIN; wait_cnt <= '0;
        end
        DRAIN: begin
          wait_cnt <= wait_cnt + 1'b1;
          if (wait_cnt == 2'd3) begin
            state <= FETCH; wait_cnt <= '0;
          end
        end
        FETCH: begin
          wait_cnt <= wait_cnt + 1'b1;
          if (wait_cnt == 2'd1) state <= ROOT;
        end
        ROOT: if (stat.sqrt_done) state <= EMIT;
        EMIT: begin
          valid <= 1'b1;
          if (stat.sqrt_sel_done) begin
            state <= IDLE; busy <= 1'b0;
          end else state <= SETUP;
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_valid_busy: assert property (@(posedge clk) disable iff (rst) valid |-> $past(busy))
    else $error("strobe outside a run");
  a_emit_once: assert property (@(posedge clk) disable iff (rst)
    valid |=> !valid) else $error("double strobe");
  a_no_load: assert property (@(posedge clk) disable iff (rst)
    state != IDLE |-> busy) else $error("busy low in run");
`endif
endmodule
`default_nettype wire

### design/minutia_triangle_code.sv
// top level of the minutia triangle code block
// depends on mtc_pkg, mtc_ctrl, mtc_datapath
// channel  | handshake      | payload
// in       | start, busy    | pos_x pos_y angle last_point
// out      | valid strobe   | code point_index last_code
// each point is one beat; a last_point beat starts the code run
// per code: setup, a scan over all n points, scan drain, neighbor fetch,
// three bit-serial roots and emit
// busy stays high for the whole run; results cannot be stalled
// synchronous reset empties the point set
`default_nettype none
module minutia_triangle_code (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic [9:0] pos_x,
  input  wire logic [9:0] pos_y,
  input  wire logic [8:0] angle,
  input  wire logic last_point,
  output logic valid,
  output logic [15:0] code,
  output logic [5:0] point_index,
  output logic last_code
);
  import mtc_pkg::*;
  mtc_cmd_t cmd;
  mtc_stat_t stat;
  mtc_ctrl u_ctrl (.clk(clk), .rst(rst), .start(start), .last_point(last_point),
    .stat(stat), .cmd(cmd), .busy(busy), .valid(valid));
  mtc_datapath u_dp (.clk(clk), .rst(rst), .cmd(cmd), .pos_x(pos_x), .pos_y(pos_y),
    .angle(angle), .stat(stat), .code(code), .point_index(point_index),
    .last_code(last_code));
endmodule
`default_nettype wire
